// ===== hdl/selected_bitmap_compactor_assert.svh =====
// ---------------------------------------------------------------------------
// selected bitmap compactor assertion macros
// shared property forms, clocked on clock and disabled in reset
// ---------------------------------------------------------------------------
`ifndef SELECTED_BITMAP_COMPACTOR_ASSERT_SVH
`define SELECTED_BITMAP_COMPACTOR_ASSERT_SVH

// same-cycle implication
`define SBC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbc assertion failed");

// next-cycle implication
`define SBC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbc assertion failed");

`endif

// ===== hdl/sbc_pkg.sv =====
// ---------------------------------------------------------------------------
// sbc_pkg
// types and constants shared by the selected bitmap compactor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbc_pkg;

   localparam int AccBits   = 64;
   localparam int LaneBits  = 8;
   localparam int Lanes     = AccBits / LaneBits;
   localparam int FifoDepth = 4;
   localparam logic [3:0] BytesFull = 4'd8;

   typedef struct packed {
      logic       first_word;
      logic [2:0] lead_count;
      logic [6:0] lead_bits;
      logic       last_word;
   } meta_type;

   typedef struct packed {
      logic [63:0] packed_word;
      logic [3:0]  byte_count;
      logic        final_out;
   } rsp_type;

   typedef struct packed {
      logic valid_a;
      logic valid_b;
   } push_type;

   typedef logic [LaneBits-1:0] lane_bits_type;
   typedef logic [3:0]          lane_cnt_type;

endpackage

// ===== hdl/sbc_lane.sv =====
// ---------------------------------------------------------------------------
// sbc_lane
// bit extract over one byte of the row word, registered
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbc_lane
   import sbc_pkg::*;
(
   input  logic          clock,
   input  logic          load,
   input  lane_bits_type val,
   input  lane_bits_type sel,
   output lane_bits_type ext_ff,
   output lane_cnt_type  cnt_ff
);

   lane_bits_type ext_in;
   lane_cnt_type  cnt_in;

   always_comb begin
      ext_in = '0;
      cnt_in = '0;
      for (int i = 0; i < LaneBits; i++) begin
         if (sel[i]) begin
            ext_in[cnt_in[2:0]] = val[i];
            cnt_in = cnt_in + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ext_ff <= ext_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hdl/sbc_merge.sv =====
// ---------------------------------------------------------------------------
// sbc_merge
// places each lane's extracted bits at its running offset, registered
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbc_merge
   import sbc_pkg::*;
(
   input  logic          clock,
   input  logic          load,
   input  lane_bits_type lane_ext [Lanes],
   input  lane_cnt_type  lane_cnt [Lanes],
   output logic [63:0]   ext_ff,
   output logic [6:0]    cnt_ff
);

   logic [63:0] ext_in;
   logic [6:0]  cnt_in;

   always_comb begin
      ext_in = '0;
      cnt_in = '0;
      for (int k = 0; k < Lanes; k++) begin
         // offset of an earlier lane never exceeds 56, so six bits shift
         ext_in = ext_in | ({56'b0, lane_ext[k]} << cnt_in[5:0]);
         cnt_in = cnt_in + {3'b0, lane_cnt[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ext_ff <= ext_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hdl/sbc_pack.sv =====
// ---------------------------------------------------------------------------
// sbc_pack
// appends extracted bits to the accumulator, forms full and flush results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbc_pack
   import sbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        consume,
   input  logic [63:0] ext,
   input  logic [6:0]  cnt,
   input  meta_type    meta,
   output push_type    push,
   output rsp_type     res_a,
   output rsp_type     res_b
);

   logic [63:0]  acc_ff, acc_in;
   logic [5:0]   held_ff, held_in;
   logic [6:0]   lead_mask;
   logic [63:0]  cur_acc;
   logic [5:0]   cur_held;
   logic [127:0] wide;
   logic [6:0]   total;
   logic         full;
   logic [63:0]  nxt_acc;
   logic [5:0]   nxt_held;
   logic         flush;
   logic [63:0]  held_mask;
   rsp_type      full_res, flush_res;

   always_comb begin
      lead_mask = 7'((8'd1 << meta.lead_count) - 8'd1);
      cur_acc   = meta.first_word ? {57'b0, meta.lead_bits & lead_mask} : acc_ff;
      cur_held  = meta.first_word ? {3'b0, meta.lead_count} : held_ff;
      wide      = ({64'b0, ext} << cur_held) | {64'b0, cur_acc};
      total     = {1'b0, cur_held} + cnt;
      full      = total[6];
      nxt_acc   = full ? wide[127:64] : wide[63:0];
      nxt_held  = total[5:0];
      flush     = meta.last_word && (nxt_held != 6'd0);
      held_mask = (64'd1 << nxt_held) - 64'd1;

      full_res.packed_word  = wide[63:0];
      full_res.byte_count   = BytesFull;
      full_res.final_out    = meta.last_word && !flush;
      flush_res.packed_word = nxt_acc & held_mask;
      flush_res.byte_count  = 4'(({1'b0, nxt_held} + 7'd7) >> 3);
      flush_res.final_out   = 1'b1;

      res_a        = full ? full_res : flush_res;
      res_b        = flush_res;
      push.valid_a = consume && (full || flush);
      push.valid_b = consume && full && flush;

      acc_in  = acc_ff;
      held_in = held_ff;
      if (consume) begin
         acc_in  = meta.last_word ? 64'd0 : nxt_acc;
         held_in = meta.last_word ? 6'd0 : nxt_held;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         held_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         held_ff <= held_in;
      end
   end

endmodule

// ===== hdl/sbc_rspq.sv =====
// ---------------------------------------------------------------------------
// sbc_rspq
// result queue taking up to two results a cycle and giving one while out_ready is high
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbc_rspq
   import sbc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  rsp_type  res_a,
   input  rsp_type  res_b,
   output logic     room_ok,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_res
);

   localparam int PtrBits = $clog2(FifoDepth);
   localparam int CntBits = $clog2(FifoDepth + 1);

   rsp_type              mem_ff [FifoDepth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]   count_ff, count_in;
   logic                 pop;
   logic [PtrBits-1:0]   wr_next;

   always_comb begin
      pop       = out_valid && out_ready;
      wr_next   = wr_ptr_ff + PtrBits'(1);
      wr_ptr_in = wr_ptr_ff + PtrBits'(push.valid_a) + PtrBits'(push.valid_b);
      rd_ptr_in = rd_ptr_ff + PtrBits'(pop);
      count_in  = count_ff + CntBits'(push.valid_a) + CntBits'(push.valid_b)
                  - CntBits'(pop);
   end

   assign out_valid = count_ff != '0;
   assign out_res   = mem_ff[rd_ptr_ff];
   // room for a pair of results from the next request
   assign room_ok   = count_ff <= CntBits'(FifoDepth - 2);

   always_ff @(posedge clock) begin
      if (push.valid_a) begin
         mem_ff[wr_ptr_ff] <= res_a;
      end
      if (push.valid_b) begin
         mem_ff[wr_next] <= res_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/selected_bitmap_compactor.sv =====
// ---------------------------------------------------------------------------
// selected_bitmap_compactor
// gathers selected non-null flags and packs them into 64-bit words
// ---------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tdata: rows, select, lead; tuser: first; tlast
//  rsp      out  rsp_tvalid/tready    tdata: packed word, byte count; tlast: final
//
//  one request per cycle while the queue has room; two register stages (lane extract,
//  lane merge), then the accumulate step writes a four-entry result queue,
//  from which results are offered in order.
//  a request giving two results (full word plus flush) gives them out in turn;
//  the queue admits a request only with room for two results.
//  reset is synchronous and clears the accumulator, stage valids and queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "selected_bitmap_compactor_assert.svh"

module selected_bitmap_compactor
   import sbc_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [63:0] nonnull_word, [127:64] select_word, [130:128] lead_count,
   // [137:131] lead_bits, [143:138] zero
   input  logic [143:0] req_tdata,
   // [0] first_word
   input  logic [0:0]   req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [63:0] packed_word, [67:64] byte_count, [71:68] zero
   output logic [71:0]  rsp_tdata,
   output logic         rsp_tlast
);

   localparam logic [63:0] WordMask = 64'((65'd1 << WORD_BITS) - 65'd1);

   logic          s1_valid_ff, s2_valid_ff;
   meta_type      s1_meta_ff, s2_meta_ff;
   meta_type      req_meta;
   logic          s1_ready, s2_ready, consume, room_ok;
   logic [63:0]   nonnull, sel;
   lane_bits_type lane_ext [Lanes];
   lane_cnt_type  lane_cnt [Lanes];
   logic [63:0]   merged_ext;
   logic [6:0]    merged_cnt;
   push_type      push;
   rsp_type       res_a, res_b, out_res;

   assign consume    = s2_valid_ff && room_ok;
   assign s2_ready   = !s2_valid_ff || room_ok;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   assign nonnull = req_tdata[63:0];
   assign sel     = req_tdata[127:64] & WordMask;

   always_comb begin
      req_meta.first_word = req_tuser[0];
      req_meta.lead_count = req_tdata[130:128];
      req_meta.lead_bits  = req_tdata[137:131];
      req_meta.last_word  = req_tlast;
   end

   for (genvar k = 0; k < Lanes; k++) begin : g_lane
      sbc_lane u_lane (
         .clock  (clock),
         .load   (s1_ready),
         .val    (nonnull[k*LaneBits +: LaneBits]),
         .sel    (sel[k*LaneBits +: LaneBits]),
         .ext_ff (lane_ext[k]),
         .cnt_ff (lane_cnt[k])
      );
   end

   sbc_merge u_merge (
      .clock    (clock),
      .load     (s2_ready),
      .lane_ext (lane_ext),
      .lane_cnt (lane_cnt),
      .ext_ff   (merged_ext),
      .cnt_ff   (merged_cnt)
   );

   sbc_pack u_pack (
      .clock   (clock),
      .reset   (reset),
      .consume (consume),
      .ext     (merged_ext),
      .cnt     (merged_cnt),
      .meta    (s2_meta_ff),
      .push    (push),
      .res_a   (res_a),
      .res_b   (res_b)
   );

   sbc_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .res_a     (res_a),
      .res_b     (res_b),
      .room_ok   (room_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = {4'b0, out_res.byte_count, out_res.packed_word};
   assign rsp_tlast = out_res.final_out;

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_meta_ff <= req_meta;
      end
      if (s2_ready) begin
         s2_meta_ff <= s1_meta_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // a second result is always the flush that closes the batch
   `SBC_ASSERT_NOW(a_pair_is_flush, push.valid_b, push.valid_a && res_b.final_out && !res_a.final_out)
   // results carry one to eight bytes
   `SBC_ASSERT_NOW(a_byte_range, rsp_tvalid, rsp_tdata[67:64] != 4'd0 && rsp_tdata[67:64] <= BytesFull)
   // a stage blocked by a full queue keeps its request
   `SBC_ASSERT_NEXT(a_stage_hold, s2_valid_ff && !room_ok, s2_valid_ff && $stable(s2_meta_ff))
   // a full word result is never cut short
   `SBC_ASSERT_NOW(a_full_not_final, push.valid_a && !res_a.final_out, res_a.byte_count == BytesFull)

endmodule
